>>> rtl/crctag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crctag_pkg
// Shared constants, types and functions of the CRC-64 / base-62 tag unit.
// ----------------------------------------------------------------------------
package crctag_pkg;

  localparam int unsigned CRC_W      = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIG_W      = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned TAG_LENGTH = 11;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned RADIX      = 62;
  // floor(x / 62) estimate for x < 62 * 256: (x * 1057) >> 16, low by at most one
  localparam int unsigned RECIP      = 1057;
  localparam int unsigned RECIP_W    = 11;
  localparam int unsigned RECIP_SH   = 16;
  localparam int unsigned DIVX_W     = DIG_W + BYTE_W;
  localparam int unsigned PROD_W     = DIVX_W + RECIP_W;

  localparam logic [CRC_W-1:0]  CRC_POLY = 64'hFEDC_BA98_7654_3210;
  localparam logic [CRC_W-1:0]  CRC_ONES = '1;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TAG_LENGTH - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CRC_W / BYTE_W - 1);

  typedef struct packed {
    logic             crc_upd;
    logic             msg_end;
    logic             div_step;
    logic             dig_wr;
    logic [IDX_W-1:0] idx;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [CRC_W-1:0] crc_table_entry(input logic [BYTE_W-1:0] idx);
    logic [CRC_W-1:0] v;
    v = {{(CRC_W-BYTE_W){1'b0}}, idx};
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIG_W'(10)) begin
      c = CHAR_W'(8'd48 + {2'b00, d});
    end else if (d < DIG_W'(36)) begin
      c = CHAR_W'(8'd87 + {2'b00, d});
    end else begin
      c = CHAR_W'(8'd29 + {2'b00, d});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/crctag_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crctag_ctrl
// Sequencer: byte intake, eight steps per tag digit, then the tag burst.
// ----------------------------------------------------------------------------
module crctag_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire                   in_last,
  output logic                  in_tready,
  input  crctag_pkg::sts_t      sts,
  output crctag_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [crctag_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [crctag_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.crc_upd = 1'b1;
          if (in_last) begin
            cmd.msg_end = 1'b1;
            state_nxt   = ST_DIV;
            step_nxt    = '0;
            idx_nxt     = crctag_pkg::IDX_LAST;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == crctag_pkg::STEP_LAST) begin
          cmd.dig_wr = 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (idx_r == crctag_pkg::IDX_LAST);
          if (idx_r == crctag_pkg::IDX_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/crctag_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crctag_dp
// CRC register, byte-wide divide-by-62 unit, digit store and output register.
// ----------------------------------------------------------------------------
module crctag_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  [crctag_pkg::BYTE_W-1:0]        data_byte,
  input  wire                                  first_byte,
  input  crctag_pkg::cmd_t                     cmd,
  output crctag_pkg::sts_t                     sts,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [crctag_pkg::CRC_W-1:0]         crc_value,
  output logic [crctag_pkg::CHAR_W-1:0]        tag_char,
  output logic                                 tag_end
);

  logic [crctag_pkg::CRC_W-1:0]   crc_r, crc_nxt, crc_base;
  logic [crctag_pkg::CRC_W-1:0]   crc_hold_r;
  logic [crctag_pkg::CRC_W-1:0]   work_r;
  logic [crctag_pkg::DIG_W-1:0]   rem_r;
  logic [crctag_pkg::DIG_W-1:0]   dig_r [crctag_pkg::TAG_LENGTH];
  logic                           out_valid_r;
  logic [crctag_pkg::CRC_W-1:0]   out_crc_r;
  logic [crctag_pkg::CHAR_W-1:0]  out_char_r;
  logic                           out_last_r;

  logic [crctag_pkg::DIVX_W-1:0]  div_x;
  logic [crctag_pkg::PROD_W-1:0]  div_prod;
  logic [crctag_pkg::BYTE_W-1:0]  q_est, q_fix;
  logic [crctag_pkg::DIVX_W-1:0]  q_times;
  logic [crctag_pkg::DIVX_W-1:0]  r_est;
  logic [crctag_pkg::DIG_W-1:0]   r_fix;

  // CRC byte update
  always_comb begin
    crc_base = first_byte ? crctag_pkg::CRC_ONES : crc_r;
    crc_nxt  = (crc_base >> 8)
             ^ crctag_pkg::crc_table_entry(crc_base[7:0] ^ data_byte)
             ^ crctag_pkg::CRC_ONES;
  end

  // one quotient byte per step
  always_comb begin
    div_x    = {rem_r, work_r[crctag_pkg::CRC_W-1 -: crctag_pkg::BYTE_W]};
    div_prod = crctag_pkg::PROD_W'(div_x) * crctag_pkg::PROD_W'(crctag_pkg::RECIP);
    q_est    = div_prod[crctag_pkg::RECIP_SH +: crctag_pkg::BYTE_W];
    q_times  = {q_est, 6'b000000} - crctag_pkg::DIVX_W'({q_est, 1'b0});
    r_est    = div_x - q_times;
    if (r_est >= crctag_pkg::DIVX_W'(crctag_pkg::RADIX)) begin
      q_fix = q_est + 1'b1;
      r_fix = crctag_pkg::DIG_W'(r_est - crctag_pkg::DIVX_W'(crctag_pkg::RADIX));
    end else begin
      q_fix = q_est;
      r_fix = r_est[crctag_pkg::DIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= crctag_pkg::CRC_ONES;
    end else if (cmd.crc_upd) begin
      crc_r <= cmd.msg_end ? crctag_pkg::CRC_ONES : crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.msg_end) begin
      crc_hold_r <= crc_nxt;
      work_r     <= crc_nxt;
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      work_r <= {work_r[crctag_pkg::CRC_W-crctag_pkg::BYTE_W-1:0], q_fix};
      rem_r  <= cmd.dig_wr ? '0 : r_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dig_wr) begin
      dig_r[cmd.idx] <= r_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_crc_r  <= crc_hold_r;
      out_char_r <= crctag_pkg::digit_char(dig_r[cmd.idx]);
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign crc_value    = out_crc_r;
  assign tag_char     = out_char_r;
  assign tag_end      = out_last_r;

endmodule
`default_nettype wire

>>> rtl/crc64_with_base62_tag_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc64_with_base62_tag_unit
// Reflected table CRC-64 over a byte stream with an 11-character base-62 tag.
// ----------------------------------------------------------------------------
// Bytes that do not end a message: one per cycle, no result.
// Final byte: eleven tag digits at eight divide steps each; the first result
// is valid after the last step, then one result per cycle while out_tready is high.
// No new byte is taken until all eleven results are loaded.
// Reset (rst_n low, synchronous) sets the CRC to all ones and clears control.
module crc64_with_base62_tag_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] first_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // [63:0] crc_value, [70:64] tag_char, [71] zero
  output logic        out_tlast   // tag_end
);

  crctag_pkg::cmd_t                     cmd;
  crctag_pkg::sts_t                     sts;
  logic [crctag_pkg::CRC_W-1:0]         crc_value;
  logic [crctag_pkg::CHAR_W-1:0]        tag_char;

  crctag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crctag_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .crc_value  (crc_value),
    .tag_char   (tag_char),
    .tag_end    (out_tlast)
  );

  assign out_tdata = {1'b0, tag_char, crc_value};

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still ready after final byte");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after final tag character");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load) |-> (!out_tvalid || out_tready))
    else $error("output overwritten before taken");

endmodule
`default_nettype wire
